// ===== rtl/swmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the stack with middle delete.
package swmd_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP,
    SH_DEL1,
    SH_DEL2
  } shift_t;

endpackage

// ===== rtl/swmd_cell.sv =====
`timescale 1ns / 1ps
// One stack cell: holds one word and takes a neighbour's word on a shift.
module swmd_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX_BITS  = 4,
  parameter int INDEX     = 0
) (
  input  logic                        clk,
  input  swmd_pkg::shift_t            shift,
  input  logic [IDX_BITS-1:0]         gap,
  input  logic signed [WORD_BITS-1:0] from_above,
  input  logic signed [WORD_BITS-1:0] from_below1,
  input  logic signed [WORD_BITS-1:0] from_below2,
  output logic signed [WORD_BITS-1:0] word
);

  logic signed [WORD_BITS-1:0] word_next;
  logic                        at_or_below_gap;

  assign at_or_below_gap = (IDX_BITS'(INDEX) >= gap);

  always_comb begin
    case (shift)
      swmd_pkg::SH_PUSH: word_next = from_above;
      swmd_pkg::SH_POP:  word_next = from_below1;
      swmd_pkg::SH_DEL1: word_next = at_or_below_gap ? from_below1 : word;
      swmd_pkg::SH_DEL2: word_next = at_or_below_gap ? from_below2 : word;
      default:           word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/stack_with_middle_delete.sv =====
`timescale 1ns / 1ps
// Top level of the bounded stack with a delete-middle operation.
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle while the input is not stalled; every cell shifts in the same cycle as its command.
// The output register holds a stalled result; input stalls only while it is held.
// Reset (synchronous, active high) empties the stack and sets the capacity to 16.
// Cell contents are not reset; only entries below the count are ever read.
module stack_with_middle_delete #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] popped_value,
  output logic [1:0]         status,
  output logic [4:0]         entries_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         capacity_limit
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int LIM_BITS = (CNT_BITS > 5) ? CNT_BITS : 5;

  logic [CNT_BITS-1:0]         count;
  logic [CNT_BITS-1:0]         count_next;
  logic [4:0]                  cap;
  swmd_pkg::shift_t            shift;
  logic [IDX_BITS-1:0]         gap;
  logic [1:0]                  status_next;
  logic signed [31:0]          popped_next;
  logic                        in_acc;
  logic                        full;
  logic                        empty;
  logic signed [WORD_BITS-1:0] push_word;
  logic signed [WORD_BITS-1:0] cells [DEPTH];

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;
  assign push_word = WORD_BITS'(push_value);
  assign empty     = (count == '0);
  assign full      = (LIM_BITS'(count) >= LIM_BITS'(cap)) ||
                     (count == CNT_BITS'(DEPTH));

  always_comb begin
    shift       = swmd_pkg::SH_HOLD;
    gap         = IDX_BITS'(count >> 1);
    count_next  = count;
    status_next = swmd_pkg::ST_DONE;
    popped_next = '0;
    unique case (opcode)
      swmd_pkg::OP_PUSH: begin
        if (full) begin
          status_next = swmd_pkg::ST_FULL;
        end else begin
          shift      = swmd_pkg::SH_PUSH;
          count_next = count + 1'b1;
        end
      end
      swmd_pkg::OP_POP: begin
        if (empty) begin
          status_next = swmd_pkg::ST_EMPTY;
        end else begin
          shift       = swmd_pkg::SH_POP;
          count_next  = count - 1'b1;
          popped_next = 32'(cells[0]);
        end
      end
      swmd_pkg::OP_DELETE: begin
        if (empty) begin
          status_next = swmd_pkg::ST_EMPTY;
        end else if (count[0]) begin
          shift      = swmd_pkg::SH_DEL1;
          count_next = count - 1'b1;
        end else begin
          shift      = swmd_pkg::SH_DEL2;
          gap        = IDX_BITS'((count >> 1) - 1'b1);
          count_next = count - CNT_BITS'(2);
        end
      end
      swmd_pkg::OP_NONE: begin
        status_next = swmd_pkg::ST_DONE;
      end
      default: begin
        status_next = swmd_pkg::ST_DONE;
      end
    endcase
  end

  // The top of the stack sits in cell 0; deeper entries lie at higher indexes.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_BITS-1:0] above;
    logic signed [WORD_BITS-1:0] below1;
    logic signed [WORD_BITS-1:0] below2;

    if (i == 0) begin : g_first
      assign above = push_word;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i + 1 < DEPTH) begin : g_b1
      assign below1 = cells[i+1];
    end else begin : g_b1_end
      assign below1 = cells[i];
    end
    if (i + 2 < DEPTH) begin : g_b2
      assign below2 = cells[i+2];
    end else begin : g_b2_end
      assign below2 = cells[i];
    end

    swmd_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_BITS  (IDX_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk         (clk),
      .shift       (in_acc ? shift : swmd_pkg::SH_HOLD),
      .gap         (gap),
      .from_above  (above),
      .from_below1 (below1),
      .from_below2 (below2),
      .word        (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap       <= swmd_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= capacity_limit;
      end
      if (in_acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      popped_value <= popped_next;
      status       <= status_next;
      entries_now  <= 5'(count_next);
    end
  end

endmodule

// ===== rtl/swmd_check.sv =====
`timescale 1ns / 1ps
// Port checker for the stack with middle delete, bound to the top level.
module swmd_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] popped_value,
  input logic [1:0]         status,
  input logic [4:0]         entries_now
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(popped_value) &&
      $stable(status) && $stable(entries_now))
    else $error("Stalled result changed.");

  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted item gave no result.");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output was free.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != swmd_pkg::ST_DONE |-> popped_value == 32'sd0)
    else $error("Refused item returned a word.");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == swmd_pkg::ST_EMPTY |-> entries_now == 5'd0)
    else $error("Empty status with entries held.");

endmodule

bind stack_with_middle_delete swmd_check u_swmd_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .popped_value (popped_value),
  .status       (status),
  .entries_now  (entries_now)
);

// ===== verif/stack_with_middle_delete_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts every stack result and compares it with the block's output.
module stack_with_middle_delete_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] push_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] popped_value,
  input  logic [1:0]         status,
  input  logic [4:0]         entries_now,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [4:0]         capacity_limit,
  output int                 fail_count,
  output int                 pending_results
);

  localparam int STACK_DEPTH = 16;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [1:0]         status;
    logic [4:0]         entries;
  } stack_result_t;

  logic signed [31:0] held_words [STACK_DEPTH];
  int unsigned        held_count = 0;
  logic [4:0]         cap_setting = swmd_pkg::CAP_RESET;
  stack_result_t      expected_results [$];
  int                 errors_seen = 0;

  function automatic void remove_middle(input int unsigned first, input int unsigned n);
    for (int unsigned i = first; i + n < held_count; i++) begin
      held_words[i] = held_words[i + n];
    end
    held_count = held_count - n;
  endfunction

  function automatic stack_result_t apply_stack_op(input logic [1:0] op,
                                                   input logic signed [31:0] value);
    stack_result_t r;
    int unsigned   limit;
    r = '0;
    r.status = swmd_pkg::ST_DONE;
    limit = (cap_setting > STACK_DEPTH) ? STACK_DEPTH : cap_setting;
    case (op)
      swmd_pkg::OP_PUSH: begin
        if (held_count >= limit) begin
          r.status = swmd_pkg::ST_FULL;
        end else begin
          held_words[held_count] = value;
          held_count++;
        end
      end
      swmd_pkg::OP_POP: begin
        if (held_count == 0) begin
          r.status = swmd_pkg::ST_EMPTY;
        end else begin
          held_count--;
          r.popped = held_words[held_count];
        end
      end
      swmd_pkg::OP_DELETE: begin
        if (held_count == 0) begin
          r.status = swmd_pkg::ST_EMPTY;
        end else if (held_count % 2 == 1) begin
          remove_middle(held_count / 2, 1);
        end else begin
          remove_middle(held_count / 2 - 1, 2);
        end
      end
      default: begin
      end
    endcase
    r.entries = held_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t got;
    stack_result_t want;
    if (rst) begin
      held_count = 0;
      cap_setting = swmd_pkg::CAP_RESET;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_setting = capacity_limit;
      end
      if (out_valid && !out_stall) begin
        got = '{popped_value, status, entries_now};
        if (expected_results.size() == 0) begin
          errors_seen++;
          if (errors_seen <= 10) begin
            $display("unexpected result: value %0d status %0d entries %0d",
                     got.popped, got.status, got.entries);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors_seen++;
            if (errors_seen <= 10) begin
              $display("mismatch (value status entries): expected %0d %0d %0d, got %0d %0d %0d",
                       want.popped, want.status, want.entries,
                       got.popped, got.status, got.entries);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_stack_op(opcode, push_value));
      end
    end
    fail_count <= errors_seen;
    pending_results <= expected_results.size();
  end

endmodule

// ===== verif/stack_with_middle_delete_tb.sv =====
`timescale 1ns / 1ps
// Top of the stack testbench: clock, reset, stimulus, receiver stalls and the verdict.
module stack_with_middle_delete_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 195;
  localparam int HOLD_CYCLES = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic [1:0]         opcode = swmd_pkg::OP_NONE;
  logic signed [31:0] push_value = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [4:0]         capacity_limit = swmd_pkg::CAP_RESET;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic [4:0]         entries_now;
  logic               cfg_ready;
  int                 fail_count;
  int                 pending_results;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic pressure_on = 1'b0;
  int   hold_cycles = 0;
  int   cycle_count = 0;

  int cap_plan   [8] = '{16, 31, 4, 0, 1, 9, 17, 16};
  int idle_plan  [8] = '{0, 83, 0, 29, 83, 0, 0, 29};
  int stall_plan [8] = '{0, 0, 83, 29, 0, 83, 0, 29};

  always #6 clk = ~clk;

  stack_with_middle_delete dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .push_value     (push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .popped_value   (popped_value),
    .status         (status),
    .entries_now    (entries_now),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_limit (capacity_limit)
  );

  stack_with_middle_delete_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .push_value      (push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .popped_value    (popped_value),
    .status          (status),
    .entries_now     (entries_now),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .capacity_limit  (capacity_limit),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // The long hold-off fills the output register so that the input side stalls.
  always @(posedge clk) begin
    if (pressure_on && hold_cycles < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    capacity_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stack_with_middle_delete_tb: errors");
    $finish;
  end

  initial begin
    int          push_pct;
    int          pick;
    logic [1:0]  op;
    logic [31:0] word;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(swmd_pkg::OP_POP, 32'h1234_5678);
    send_item(swmd_pkg::OP_DELETE, 32'hFFFF_FFFF);
    send_item(swmd_pkg::OP_NONE, 32'h0);
    send_item(swmd_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_item(swmd_pkg::OP_PUSH, 32'h8000_0000);
    send_item(swmd_pkg::OP_PUSH, 32'h0000_0000);
    send_item(swmd_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_item(swmd_pkg::OP_PUSH, 32'h1234_5678);
    send_item(swmd_pkg::OP_DELETE, 32'h0);
    send_item(swmd_pkg::OP_DELETE, 32'h0);
    send_item(swmd_pkg::OP_NONE, 32'hFFFF_FFFF);
    send_item(swmd_pkg::OP_DELETE, 32'h0);
    send_item(swmd_pkg::OP_PUSH, 32'hA5A5_A5A5);
    send_item(swmd_pkg::OP_DELETE, 32'h0);
    send_item(swmd_pkg::OP_PUSH, 32'h8000_0000);
    send_item(swmd_pkg::OP_POP, 32'h0);
    send_item(swmd_pkg::OP_POP, 32'h0);
    set_capacity(5'd2);
    send_item(swmd_pkg::OP_PUSH, 32'h0000_0001);
    send_item(swmd_pkg::OP_PUSH, 32'h0000_0002);
    send_item(swmd_pkg::OP_PUSH, 32'h0000_0003);
    set_capacity(5'd1);
    send_item(swmd_pkg::OP_PUSH, 32'h0000_0004);
    send_item(swmd_pkg::OP_POP, 32'h0);
    send_item(swmd_pkg::OP_PUSH, 32'h0000_0005);
    send_item(swmd_pkg::OP_POP, 32'h0);
    send_item(swmd_pkg::OP_POP, 32'h0);

    for (int phase = 0; phase < 8; phase++) begin
      set_capacity(cap_plan[phase][4:0]);
      idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      if (phase == 6) begin
        pressure_on <= 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_pct = ((n / 24) % 2 == 0) ? 75 : 30;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
          op = swmd_pkg::OP_PUSH;
        end else begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            op = swmd_pkg::OP_NONE;
          end else if (pick < 10) begin
            op = swmd_pkg::OP_POP;
          end else begin
            op = swmd_pkg::OP_DELETE;
          end
        end
        case ($urandom_range(0, 9))
          0: word = 32'h8000_0000;
          1: word = 32'h7FFF_FFFF;
          2: word = 32'h0000_0000;
          3: word = 32'hFFFF_FFFF;
          default: word = $urandom;
        endcase
        send_item(op, word);
      end
    end

    drain_results();
    if (fail_count == 0 && pending_results == 0) begin
      $display("stack_with_middle_delete_tb: clean");
    end else begin
      $display("stack_with_middle_delete_tb: errors");
    end
    $finish;
  end

endmodule
